>>> hw/rtl/odc_pkg.sv
// Shared types, constants and helpers for the offline dynamic connectivity block.
package odc_pkg;

  localparam int MAX_EVENTS = 64;
  localparam int MAX_NODES = 64;
  localparam int VW = 6;
  localparam int CW = 7;
  localparam int STACK_DEPTH = 8;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_DEL = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [VW-1:0] low;
    logic [VW-1:0] high;
    logic [CW-1:0] pidx;
    logic pval;
  } event_t;

  typedef struct packed {
    logic [CW-1:0] s;
    logic [CW-1:0] e;
    logic [CW-1:0] keep;
    logic ph;
  } frame_t;

  typedef struct packed {
    logic [VW-1:0] par_ra;
    logic [VW-1:0] siz_ra;
    logic [VW-1:0] hist_ra;
    logic par_we;
    logic [VW-1:0] par_wa;
    logic [VW-1:0] par_wd;
    logic siz_we;
    logic [VW-1:0] siz_wa;
    logic [CW-1:0] siz_wd;
    logic hist_we;
    logic [VW-1:0] hist_wa;
    logic [VW-1:0] hist_wd;
  } uf_req_t;

  function automatic logic [CW-1:0] eff_nodes(input logic [CW-1:0] n);
    logic [CW-1:0] r;
    r = n;
    if (n == '0) r = CW'(1);
    if (n > CW'(MAX_NODES)) r = CW'(MAX_NODES);
    return r;
  endfunction

endpackage

>>> hw/rtl/odc_uf_mem.sv
// Union-find parent, size and history stores with a post-reset init sweep.
module odc_uf_mem import odc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  uf_req_t req,
  output logic [VW-1:0] par_q,
  output logic [CW-1:0] siz_q,
  output logic [VW-1:0] hist_q,
  output logic ready
);

  logic [VW-1:0] parent_mem [MAX_NODES];
  logic [CW-1:0] size_mem [MAX_NODES];
  logic [VW-1:0] hist_mem [MAX_NODES];
  logic [CW-1:0] clr;

  assign ready = clr[CW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (!ready) begin
      clr <= clr + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!ready) begin
      parent_mem[clr[VW-1:0]] <= clr[VW-1:0];
      size_mem[clr[VW-1:0]] <= CW'(1);
    end else begin
      if (req.par_we) parent_mem[req.par_wa] <= req.par_wd;
      if (req.siz_we) size_mem[req.siz_wa] <= req.siz_wd;
    end
    if (req.hist_we) hist_mem[req.hist_wa] <= req.hist_wd;
    par_q <= parent_mem[req.par_ra];
    siz_q <= size_mem[req.siz_ra];
    hist_q <= hist_mem[req.hist_ra];
  end

endmodule

>>> hw/rtl/offline_dynamic_connectivity_top.sv
// Top level: event loader, divide-and-conquer sequencer and rollback union-find control.
//
// Usage: write node_count (node_count_we high for one cycle) while the block
// is idle. Send events on the input channel (in_valid, in_stall; fields op,
// end_a, end_b, last_event). A delete scans the stored events backward for
// its partner add. The word with last_event set starts the batch computation:
// a pass over all stored events, then the divide-and-conquer sweep, where
// each stored edge is checked, each union runs two uncompressed finds on the
// shared union-find memories and each rollback reads the history, parent and
// sizes before it restores a parent and a size. The computation takes longer
// for batches with many long-lived edges.
// in_stall stays high during the computation. Answers leave on the output
// channel (out_valid, out_stall; components, last_answer) in query order,
// last_answer set on the final one; a stalled receiver holds the sweep.
// After reset the union-find parent and size memories are initialized while
// in_stall stays high.
module offline_dynamic_connectivity_top import odc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic node_count_we,
  input  logic [6:0] node_count,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] op,
  input  logic [5:0] end_a,
  input  logic [5:0] end_b,
  input  logic last_event,
  output logic out_valid,
  input  logic out_stall,
  output logic [6:0] components,
  output logic last_answer
);

  localparam logic [4:0] S_CLR = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_LD_SRCH = 5'd2;
  localparam logic [4:0] S_LD_CHK = 5'd3;
  localparam logic [4:0] S_LD_WRI = 5'd4;
  localparam logic [4:0] S_FIN = 5'd5;
  localparam logic [4:0] S_FIN_CHK = 5'd6;
  localparam logic [4:0] S_ENTER = 5'd7;
  localparam logic [4:0] S_LEAF = 5'd8;
  localparam logic [4:0] S_EMIT = 5'd9;
  localparam logic [4:0] S_SCAN = 5'd10;
  localparam logic [4:0] S_SCAN_CHK = 5'd11;
  localparam logic [4:0] S_FA = 5'd12;
  localparam logic [4:0] S_FA_CHK = 5'd13;
  localparam logic [4:0] S_FB = 5'd14;
  localparam logic [4:0] S_FB_CHK = 5'd15;
  localparam logic [4:0] S_JSA = 5'd16;
  localparam logic [4:0] S_JSB = 5'd17;
  localparam logic [4:0] S_JOIN = 5'd18;
  localparam logic [4:0] S_SCAN_DONE = 5'd19;
  localparam logic [4:0] S_RET = 5'd20;
  localparam logic [4:0] S_UNDO = 5'd21;
  localparam logic [4:0] S_UA = 5'd22;
  localparam logic [4:0] S_UP = 5'd23;
  localparam logic [4:0] S_USA = 5'd24;
  localparam logic [4:0] S_USP = 5'd25;
  localparam logic [4:0] S_DONE = 5'd26;

  logic [4:0] state;
  logic [CW-1:0] node_reg;
  logic [CW-1:0] ev_count;
  logic [CW-1:0] q_total;
  logic [CW-1:0] emitted;
  logic [CW-1:0] hd;
  logic [CW-1:0] set_count;
  logic [3:0] sp;
  frame_t stack [STACK_DEPTH];
  frame_t top_f;

  logic [1:0] l_op;
  logic [VW-1:0] l_lo;
  logic [VW-1:0] l_hi;
  logic l_last;
  logic [CW-1:0] l_pidx;
  logic l_pval;
  logic [CW-1:0] j;

  logic [CW-1:0] cur_s;
  logic [CW-1:0] cur_e;
  logic [CW-1:0] scan_i;
  logic [CW-1:0] scan_lo;
  logic [CW-1:0] scan_bound;
  logic scan_mode;
  logic [VW-1:0] x;
  logic [VW-1:0] eb;
  logic [VW-1:0] ra;
  logic [VW-1:0] rb;
  logic [CW-1:0] sa;
  logic [VW-1:0] ua;
  logic [VW-1:0] up;
  logic [CW-1:0] usa;

  event_t ev_mem [MAX_EVENTS];
  event_t ev_q;
  logic [VW-1:0] ev_ra;
  logic ev_we;
  logic [VW-1:0] ev_wa;
  event_t ev_wd;

  uf_req_t req;
  logic [VW-1:0] par_q;
  logic [CW-1:0] siz_q;
  logic [VW-1:0] hist_q;
  logic uf_ready;

  logic [CW-1:0] n_eff;
  logic [CW:0] mid_sum;
  logic [CW-1:0] mid;
  logic scan_hit;
  logic accept;
  logic out_free;

  odc_uf_mem u_uf (
    .clk(clk), .rst(rst), .req(req),
    .par_q(par_q), .siz_q(siz_q), .hist_q(hist_q), .ready(uf_ready)
  );

  assign n_eff = eff_nodes(node_reg);
  assign top_f = stack[sp[2:0] - 3'd1];
  assign mid_sum = {1'b0, cur_s} + {1'b0, cur_e};
  assign mid = mid_sum[CW:1];
  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign scan_hit = (ev_q.kind == OP_ADD || ev_q.kind == OP_DEL) && ev_q.pval &&
                    (scan_mode ? (ev_q.pidx >= scan_bound) : (ev_q.pidx < scan_bound)) &&
                    ({1'b0, ev_q.low} < n_eff) && ({1'b0, ev_q.high} < n_eff);

  always_ff @(posedge clk) begin
    if (ev_we) ev_mem[ev_wa] <= ev_wd;
    ev_q <= ev_mem[ev_ra];
  end

  always_comb begin
    ev_ra = '0;
    ev_we = 1'b0;
    ev_wa = '0;
    ev_wd = '0;
    req = '0;
    case (state)
      S_LD_SRCH: ev_ra = VW'(j - CW'(1));
      S_LD_CHK: begin
        ev_wa = j[VW-1:0];
        ev_wd = ev_q;
        ev_wd.pidx = ev_count;
        ev_wd.pval = 1'b1;
        ev_we = ev_q.kind == OP_ADD && !ev_q.pval && ev_q.low == l_lo && ev_q.high == l_hi;
      end
      S_LD_WRI: begin
        ev_we = 1'b1;
        ev_wa = ev_count[VW-1:0];
        ev_wd.kind = l_op;
        ev_wd.low = l_lo;
        ev_wd.high = l_hi;
        ev_wd.pidx = l_pidx;
        ev_wd.pval = l_pval;
      end
      S_FIN: ev_ra = j[VW-1:0];
      S_FIN_CHK: begin
        ev_wa = j[VW-1:0];
        ev_wd = ev_q;
        ev_wd.pidx = ev_count;
        ev_wd.pval = 1'b1;
        ev_we = ev_q.kind == OP_ADD && !ev_q.pval;
      end
      S_ENTER: ev_ra = cur_s[VW-1:0];
      S_SCAN: ev_ra = VW'(scan_i - CW'(1));
      S_FA, S_FB: req.par_ra = x;
      S_JSA: req.siz_ra = ra;
      S_JSB: req.siz_ra = rb;
      S_JOIN: begin
        req.siz_we = 1'b1;
        req.siz_wd = sa + siz_q;
        req.par_we = 1'b1;
        req.hist_we = 1'b1;
        req.hist_wa = hd[VW-1:0];
        if (sa > siz_q) begin
          req.siz_wa = ra;
          req.par_wa = rb;
          req.par_wd = ra;
          req.hist_wd = rb;
        end else begin
          req.siz_wa = rb;
          req.par_wa = ra;
          req.par_wd = rb;
          req.hist_wd = ra;
        end
      end
      S_UNDO: req.hist_ra = VW'(hd - CW'(1));
      S_UA: req.par_ra = hist_q;
      S_UP: req.siz_ra = ua;
      S_USA: req.siz_ra = up;
      S_USP: begin
        req.siz_we = 1'b1;
        req.siz_wa = up;
        req.siz_wd = siz_q - usa;
        req.par_we = 1'b1;
        req.par_wa = ua;
        req.par_wd = ua;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_reg <= CW'(MAX_NODES);
    end else if (node_count_we) begin
      node_reg <= node_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
      components <= set_count;
      last_answer <= (emitted == q_total - CW'(1));
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      ev_count <= '0;
      q_total <= '0;
      emitted <= '0;
      hd <= '0;
      sp <= '0;
    end else begin
      case (state)
        S_CLR: if (uf_ready) state <= S_IDLE;
        S_IDLE: begin
          if (accept) begin
            l_op <= op;
            l_lo <= (op < OP_QUERY) ? ((end_a > end_b) ? end_b : end_a) : '0;
            l_hi <= (op < OP_QUERY) ? ((end_a > end_b) ? end_a : end_b) : '0;
            l_last <= last_event;
            l_pidx <= '0;
            l_pval <= 1'b0;
            j <= ev_count;
            if (ev_count < CW'(MAX_EVENTS)) begin
              state <= (op == OP_DEL) ? S_LD_SRCH : S_LD_WRI;
            end else if (last_event) begin
              j <= '0;
              state <= S_FIN;
            end
          end
        end
        S_LD_SRCH: begin
          if (j == '0) begin
            state <= S_LD_WRI;
          end else begin
            j <= j - CW'(1);
            state <= S_LD_CHK;
          end
        end
        S_LD_CHK: begin
          if (ev_we) begin
            l_pidx <= j;
            l_pval <= 1'b1;
            state <= S_LD_WRI;
          end else begin
            state <= S_LD_SRCH;
          end
        end
        S_LD_WRI: begin
          ev_count <= ev_count + CW'(1);
          if (l_op == OP_QUERY) q_total <= q_total + CW'(1);
          j <= '0;
          state <= l_last ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          if (j == ev_count) begin
            set_count <= n_eff;
            hd <= '0;
            sp <= '0;
            cur_s <= '0;
            cur_e <= ev_count;
            state <= (ev_count == '0) ? S_DONE : S_ENTER;
          end else begin
            state <= S_FIN_CHK;
          end
        end
        S_FIN_CHK: begin
          j <= j + CW'(1);
          state <= S_FIN;
        end
        S_ENTER: begin
          if (cur_s + CW'(1) == cur_e) begin
            state <= S_LEAF;
          end else begin
            stack[sp[2:0]] <= '{s: cur_s, e: cur_e, keep: hd, ph: 1'b0};
            sp <= sp + 4'd1;
            scan_i <= cur_e;
            scan_lo <= mid;
            scan_bound <= cur_s;
            scan_mode <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_LEAF: state <= (ev_q.kind == OP_QUERY) ? S_EMIT : S_RET;
        S_EMIT: begin
          if (out_free) begin
            emitted <= emitted + CW'(1);
            state <= S_RET;
          end
        end
        S_SCAN: begin
          if (scan_i == scan_lo) begin
            state <= S_SCAN_DONE;
          end else begin
            scan_i <= scan_i - CW'(1);
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          x <= ev_q.low;
          eb <= ev_q.high;
          state <= scan_hit ? S_FA : S_SCAN;
        end
        S_FA: state <= S_FA_CHK;
        S_FA_CHK: begin
          if (par_q == x) begin
            ra <= x;
            x <= eb;
            state <= S_FB;
          end else begin
            x <= par_q;
            state <= S_FA;
          end
        end
        S_FB: state <= S_FB_CHK;
        S_FB_CHK: begin
          if (par_q == x) begin
            rb <= x;
            state <= (x == ra || hd >= CW'(MAX_NODES)) ? S_SCAN : S_JSA;
          end else begin
            x <= par_q;
            state <= S_FB;
          end
        end
        S_JSA: state <= S_JSB;
        S_JSB: begin
          sa <= siz_q;
          state <= S_JOIN;
        end
        S_JOIN: begin
          hd <= hd + CW'(1);
          set_count <= set_count - CW'(1);
          state <= S_SCAN;
        end
        S_SCAN_DONE: begin
          if (!top_f.ph) begin
            cur_s <= top_f.s;
            cur_e <= CW'(({1'b0, top_f.s} + {1'b0, top_f.e}) >> 1);
          end else begin
            cur_s <= CW'(({1'b0, top_f.s} + {1'b0, top_f.e}) >> 1);
            cur_e <= top_f.e;
          end
          state <= S_ENTER;
        end
        S_RET: state <= (sp == '0) ? S_DONE : S_UNDO;
        S_UNDO: begin
          if (hd > top_f.keep) begin
            state <= S_UA;
          end else if (!top_f.ph) begin
            stack[sp[2:0] - 3'd1].ph <= 1'b1;
            scan_i <= CW'(({1'b0, top_f.s} + {1'b0, top_f.e}) >> 1);
            scan_lo <= top_f.s;
            scan_bound <= top_f.e;
            scan_mode <= 1'b1;
            state <= S_SCAN;
          end else begin
            sp <= sp - 4'd1;
            state <= S_RET;
          end
        end
        S_UA: begin
          ua <= hist_q;
          state <= S_UP;
        end
        S_UP: begin
          up <= par_q;
          state <= S_USA;
        end
        S_USA: begin
          usa <= siz_q;
          state <= S_USP;
        end
        S_USP: begin
          hd <= hd - CW'(1);
          set_count <= set_count + CW'(1);
          state <= S_UNDO;
        end
        S_DONE: begin
          ev_count <= '0;
          q_total <= '0;
          emitted <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sim/odc_checker.sv
// Connectivity checker: watches both channels, predicts component counts and compares them.
`timescale 1ns / 100ps
module odc_checker import odc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic node_count_we,
  input  logic [6:0] node_count,
  input  logic in_valid,
  input  logic in_stall,
  input  logic [1:0] op,
  input  logic [5:0] end_a,
  input  logic [5:0] end_b,
  input  logic last_event,
  input  logic out_valid,
  input  logic out_stall,
  input  logic [6:0] components,
  input  logic last_answer,
  output int   errors,
  output int   pending,
  output int   words_in,
  output int   answers
);

  typedef struct packed {
    logic [6:0] count;
    logic       last;
  } answer_t;

  answer_t     answer_q[$];
  logic [1:0]  ev_kind[MAX_EVENTS];
  logic [5:0]  ev_low[MAX_EVENTS];
  logic [5:0]  ev_high[MAX_EVENTS];
  int          ev_partner[MAX_EVENTS];
  bit          ev_paired[MAX_EVENTS];
  int          ev_total;
  logic [6:0]  nodes_reg;
  logic [5:0]  parent[64];
  logic [6:0]  size_of[64];
  logic [5:0]  history[64];
  int          hist_len;
  int          sets;

  function automatic int live_nodes();
    int n;
    n = nodes_reg;
    if (n < 1) n = 1;
    if (n > MAX_NODES) n = MAX_NODES;
    return n;
  endfunction

  function automatic void forest_clear();
    for (int v = 0; v < 64; v++) begin
      parent[v] = v[5:0];
      size_of[v] = 7'd1;
    end
    hist_len = 0;
    sets = live_nodes();
  endfunction

  function automatic int root_of(int v);
    int g;
    g = 0;
    while (g < 64 && parent[v] != v[5:0]) begin
      v = parent[v];
      g++;
    end
    return v;
  endfunction

  function automatic void join_ends(int a, int b);
    int n;
    int t;
    n = live_nodes();
    if (a >= n || b >= n) return;
    a = root_of(a);
    b = root_of(b);
    if (a == b || hist_len >= 64) return;
    if (size_of[a] > size_of[b]) begin
      t = a; a = b; b = t;
    end
    size_of[b] = size_of[b] + size_of[a];
    history[hist_len] = a[5:0];
    hist_len++;
    parent[a] = b[5:0];
    sets--;
  endfunction

  function automatic void roll_back(int keep);
    int a;
    int p;
    while (hist_len > keep) begin
      hist_len--;
      a = history[hist_len];
      p = parent[a];
      size_of[p] = size_of[p] - size_of[a];
      parent[a] = a[5:0];
      sets++;
    end
  endfunction

  function automatic bit is_edge(int i);
    return (ev_kind[i] == OP_ADD || ev_kind[i] == OP_DEL) && ev_paired[i];
  endfunction

  function automatic void solve_batch();
    int fs[16], fe[16], fk[16], fp[16];
    int sp, s, e, m, first;
    answer_t r;
    first = answer_q.size();
    sp = 0;
    fs[0] = 0; fe[0] = ev_total; fp[0] = 0; fk[0] = 0;
    sp = 1;
    while (sp > 0) begin
      s = fs[sp-1];
      e = fe[sp-1];
      m = (s + e) / 2;
      if (s + 1 == e) begin
        if (ev_kind[s] == OP_QUERY) begin
          r.count = sets[6:0];
          r.last = 1'b0;
          answer_q.insert(answer_q.size(), r);
        end
        sp--;
      end else if (fp[sp-1] == 0) begin
        fk[sp-1] = hist_len;
        for (int i = e - 1; i >= m; i--)
          if (is_edge(i) && ev_partner[i] < s) join_ends(ev_low[i], ev_high[i]);
        fp[sp-1] = 1;
        fs[sp] = s; fe[sp] = m; fp[sp] = 0;
        sp++;
      end else if (fp[sp-1] == 1) begin
        roll_back(fk[sp-1]);
        for (int i = m - 1; i >= s; i--)
          if (is_edge(i) && ev_partner[i] >= e) join_ends(ev_low[i], ev_high[i]);
        fp[sp-1] = 2;
        fs[sp] = m; fe[sp] = e; fp[sp] = 0;
        sp++;
      end else begin
        roll_back(fk[sp-1]);
        sp--;
      end
    end
    if (answer_q.size() > first) answer_q[answer_q.size()-1].last = 1'b1;
  endfunction

  function automatic void take_event(logic [1:0] k, logic [5:0] a, logic [5:0] b, logic fin);
    int i;
    logic [5:0] t;
    if (ev_total < MAX_EVENTS) begin
      i = ev_total;
      ev_total++;
      if (a > b) begin
        t = a; a = b; b = t;
      end
      ev_kind[i] = k;
      ev_low[i] = (k == OP_ADD || k == OP_DEL) ? a : 6'd0;
      ev_high[i] = (k == OP_ADD || k == OP_DEL) ? b : 6'd0;
      ev_partner[i] = 0;
      ev_paired[i] = 1'b0;
      if (k == OP_DEL) begin
        for (int j = i - 1; j >= 0; j--) begin
          if (ev_kind[j] == OP_ADD && !ev_paired[j] && ev_low[j] == a && ev_high[j] == b) begin
            ev_partner[j] = i;
            ev_paired[j] = 1'b1;
            ev_partner[i] = j;
            ev_paired[i] = 1'b1;
            break;
          end
        end
      end
    end
    if (!fin) return;
    if (ev_total > 0) begin
      for (int i = 0; i < ev_total; i++)
        if (ev_kind[i] == OP_ADD && !ev_paired[i]) begin
          ev_partner[i] = ev_total;
          ev_paired[i] = 1'b1;
        end
      forest_clear();
      solve_batch();
    end
    ev_total = 0;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      nodes_reg = 7'd64;
      ev_total = 0;
      answer_q.delete();
      errors <= 0;
      pending <= 0;
      words_in <= 0;
      answers <= 0;
    end else begin
      if (node_count_we) nodes_reg = node_count;
      if (in_valid && !in_stall) begin
        take_event(op, end_a, end_b, last_event);
        words_in <= words_in + 1;
      end
      if (out_valid && !out_stall) begin
        answers <= answers + 1;
        if (answer_q.size() == 0) begin
          if (errors < 10) $display("unexpected answer: components %0d last %0b",
                                    components, last_answer);
          errors <= errors + 1;
        end else begin
          want = answer_q.pop_front();
          if (want.count !== components || want.last !== last_answer) begin
            if (errors < 10)
              $display("mismatch: expected components %0d last %0b, got %0d last %0b",
                       want.count, want.last, components, last_answer);
            errors <= errors + 1;
          end
        end
      end
      pending <= answer_q.size();
    end
  end

endmodule

>>> sim/tb.sv
// Testbench top: clock, reset, event stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module tb;
  import odc_pkg::*;

  localparam int LIMIT = 3000000;
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic node_count_we = 1'b0;
  logic [6:0] node_count = 7'd64;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] op = OP_ADD;
  logic [5:0] end_a = '0;
  logic [5:0] end_b = '0;
  logic last_event = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [6:0] components;
  logic last_answer;

  int errors, pending, words_in, answers;
  int send_idle = 0;
  int recv_idle = 0;
  int cycles = 0;
  int sent = 0;
  int hold_left = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  offline_dynamic_connectivity_top DUT (.*);

  odc_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_go && !hold_done && hold_left == 0) begin
      hold_left <= 600;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  task automatic send_word(logic [1:0] k, logic [5:0] a, logic [5:0] b, logic fin);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= k;
    end_a <= a;
    end_b <= b;
    last_event <= fin;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic set_nodes(logic [6:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || in_stall) @(posedge clk);
    node_count_we <= 1'b1;
    node_count <= v;
    @(posedge clk);
    node_count_we <= 1'b0;
  endtask

  task automatic random_batch(int nodes);
    logic [5:0] la[$], lb[$];
    int len, span, r, idx;
    logic [5:0] a, b;
    logic [1:0] k;
    len = ($urandom_range(15) == 0) ? $urandom_range(60, 70) : $urandom_range(2, 22);
    span = (nodes < 63) ? nodes + 1 : 63;
    for (int n = 0; n < len; n++) begin
      r = $urandom_range(99);
      a = 6'($urandom_range(span));
      b = 6'($urandom_range(span));
      if ($urandom_range(19) == 0) a = 6'($urandom_range(63));
      if (r < 40) begin
        k = OP_ADD;
        la.insert(la.size(), a);
        lb.insert(lb.size(), b);
      end else if (r < 62) begin
        k = OP_DEL;
        if (la.size() > 0 && $urandom_range(9) != 0) begin
          idx = $urandom_range(la.size() - 1);
          a = lb[idx];
          b = la[idx];
          la.delete(idx);
          lb.delete(idx);
        end
      end else if (r < 97) begin
        k = OP_QUERY;
      end else begin
        k = OP_SPARE;
      end
      send_word(k, a, b, n == len - 1);
    end
  endtask

  initial begin
    logic [6:0] cfg[6];
    cfg = '{7'd12, 7'd1, 7'd64, 7'd0, 7'd127, 7'd5};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // directed batch at 64 nodes: extremes, repeated add, unmatched delete, op three
    send_word(OP_QUERY, 6'd63, 6'd63, 1'b0);
    send_word(OP_ADD, 6'd0, 6'd63, 1'b0);
    send_word(OP_QUERY, 6'd0, 6'd0, 1'b0);
    send_word(OP_ADD, 6'd63, 6'd0, 1'b0);
    send_word(OP_DEL, 6'd0, 6'd63, 1'b0);
    send_word(OP_QUERY, 6'd0, 6'd0, 1'b0);
    send_word(OP_DEL, 6'd63, 6'd0, 1'b0);
    send_word(OP_QUERY, 6'd0, 6'd0, 1'b0);
    send_word(OP_DEL, 6'd5, 6'd7, 1'b0);
    send_word(OP_SPARE, 6'd42, 6'd21, 1'b0);
    send_word(OP_ADD, 6'd62, 6'd1, 1'b0);
    send_word(OP_ADD, 6'd1, 6'd2, 1'b0);
    send_word(OP_QUERY, 6'd0, 6'd0, 1'b0);
    send_word(OP_DEL, 6'd2, 6'd1, 1'b0);
    send_word(OP_QUERY, 6'd0, 6'd0, 1'b1);
    // batch without queries
    send_word(OP_ADD, 6'd1, 6'd2, 1'b0);
    send_word(OP_DEL, 6'd1, 6'd2, 1'b1);
    send_word(OP_QUERY, 6'd0, 6'd0, 1'b1);
    for (int ph = 0; ph < 6; ph++) begin
      set_nodes(cfg[ph]);
      send_idle = (ph < 2) ? 23 : (ph < 4) ? 61 : 0;
      recv_idle = (ph < 2) ? 61 : (ph < 4) ? 23 : 0;
      if (ph == 1) hold_go <= 1'b1;
      while (sent < 20 + 78 * (ph + 1)) random_batch(cfg[ph]);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8000) @(posedge clk);
    $display("Sent %0d event words over six node-count settings, checked %0d answers.",
             words_in, answers);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
